// ===== design/csb_pkg.sv =====
package csb_pkg;

  localparam int CAPACITY    = 32;
  localparam int VALUE_WIDTH = 32;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  localparam int CMD_W    = 3;
  localparam int ITEM_W   = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;

  localparam int IN_DATA_W  = ((CMD_W + ITEM_W + 7) / 8) * 8;
  localparam int OUT_USED_W = ITEM_W + STATUS_W + POS_W + POS_W + 1;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_REWIND  = 3'd0,
    CMD_ADVANCE = 3'd1,
    CMD_INSERT  = 3'd2,
    CMD_ATTACH  = 3'd3,
    CMD_REMOVE  = 3'd4,
    CMD_READ    = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

endpackage

// ===== design/cursor_sequence_buffer.sv =====
// Channel  Direction  Handshake           Payload
// in       input      in_tvalid/tready    command, entry_value
// out      output     out_tvalid/tready   item_value, status, item_count, cursor_pos, has_current
//
// An item passes from acceptance through S_MOVE, where entries shift one at a time, since the
// item memory has a single write port; then through S_PUT when a new value is written; then
// through S_LOOK and S_RESULT, after which the next item can be accepted.
// Reset clears the count, the cursor and the control state; memory contents are not cleared.
// A new item is accepted while a result waits; a stalled output holds the block before
// its result is loaded.
module cursor_sequence_buffer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // command [2:0], entry_value [34:3], zero padding above
  input  logic [csb_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // item_value [31:0], status [33:32], item_count [39:34], cursor_pos [45:40],
  // has_current [46], zero padding above
  output logic [csb_pkg::OUT_DATA_W-1:0] out_tdata
);

  import csb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_PUT,
    S_LOOK,
    S_RESULT
  } state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        cursor_r;
  status_t                 status_r;
  logic                    put_r;
  logic [VALUE_WIDTH-1:0]  val_r;
  logic [ADDR_W-1:0]       put_addr_r;
  logic                    up_r;
  logic [ADDR_W-1:0]       src_r;
  logic [CNT_W-1:0]        left_r;
  logic                    pend_r;
  logic [ADDR_W-1:0]       pend_addr_r;
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;

  cmd_t                    cmd;
  logic [ITEM_W-1:0]       entry_value;
  logic                    cur;
  logic                    full;
  logic [CNT_W-1:0]        pos;
  logic [CNT_W-1:0]        cursor_nxt;
  logic [CNT_W-1:0]        count_nxt;
  status_t                 status_nxt;
  logic                    put_nxt;
  logic                    up_nxt;
  logic [ADDR_W-1:0]       src_nxt;
  logic [CNT_W-1:0]        left_nxt;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [VALUE_WIDTH-1:0]  ram_wdata;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [VALUE_WIDTH-1:0]  ram_rdata;

  logic                    has_cur;
  logic [ITEM_W-1:0]       item_value;

  assign cmd         = cmd_t'(in_tdata[CMD_W-1:0]);
  assign entry_value = in_tdata[CMD_W+ITEM_W-1:CMD_W];
  assign cur         = cursor_r < count_r;
  assign full        = count_r >= CNT_W'(CAPACITY);

  always_comb begin
    cursor_nxt = cursor_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    put_nxt    = 1'b0;
    up_nxt     = 1'b1;
    src_nxt    = '0;
    left_nxt   = '0;
    pos        = '0;
    case (cmd)
      CMD_REWIND: begin
        cursor_nxt = '0;
      end
      CMD_ADVANCE: begin
        if (cur) begin
          cursor_nxt = cursor_r + CNT_W'(1);
        end else begin
          status_nxt = ST_NONE;
        end
      end
      CMD_INSERT, CMD_ATTACH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          if (cmd == CMD_INSERT) begin
            pos = cur ? cursor_r : '0;
          end else begin
            pos = cur ? cursor_r + CNT_W'(1) : count_r;
          end
          cursor_nxt = pos;
          count_nxt  = count_r + CNT_W'(1);
          put_nxt    = 1'b1;
          up_nxt     = 1'b1;
          src_nxt    = ADDR_W'(count_r - CNT_W'(1));
          left_nxt   = count_r - pos;
        end
      end
      CMD_REMOVE: begin
        if (cur) begin
          count_nxt = count_r - CNT_W'(1);
          up_nxt    = 1'b0;
          src_nxt   = ADDR_W'(cursor_r + CNT_W'(1));
          left_nxt  = count_r - cursor_r - CNT_W'(1);
        end else begin
          status_nxt = ST_NONE;
        end
      end
      default: begin
        if (!cur) begin
          status_nxt = ST_NONE;
        end
      end
    endcase
  end

  assign ram_raddr = (state_r == S_MOVE) ? src_r : ADDR_W'(cursor_r);
  assign ram_we    = pend_r || (state_r == S_PUT);
  assign ram_waddr = pend_r ? pend_addr_r : put_addr_r;
  assign ram_wdata = pend_r ? ram_rdata : val_r;

  csb_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign has_cur    = cursor_r < count_r;
  assign item_value = has_cur ? ITEM_W'(ram_rdata) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cursor_r   <= cursor_nxt;
            count_r    <= count_nxt;
            status_r   <= status_nxt;
            put_r      <= put_nxt;
            val_r      <= VALUE_WIDTH'(entry_value);
            put_addr_r <= ADDR_W'(pos);
            up_r       <= up_nxt;
            src_r      <= src_nxt;
            left_r     <= left_nxt;
            state_r    <= S_MOVE;
          end
        end
        S_MOVE: begin
          if (left_r != '0) begin
            pend_r      <= 1'b1;
            pend_addr_r <= up_r ? src_r + ADDR_W'(1) : src_r - ADDR_W'(1);
            src_r       <= up_r ? src_r - ADDR_W'(1) : src_r + ADDR_W'(1);
            left_r      <= left_r - CNT_W'(1);
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              state_r <= put_r ? S_PUT : S_LOOK;
            end
          end
        end
        S_PUT: begin
          state_r <= S_LOOK;
        end
        S_LOOK: begin
          state_r <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {{OUT_PAD_W{1'b0}}, has_cur, POS_W'(cursor_r), POS_W'(count_r),
                            status_r, item_value};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/csb_ram.sv =====
module csb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import csb_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int QUIET_ITEMS  = 60;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = CAPACITY + 8;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                has_current;
    logic [POS_W-1:0]    cursor_pos;
    logic [POS_W-1:0]    item_count;
    logic [STATUS_W-1:0] status;
    logic [ITEM_W-1:0]   item_value;
  } seq_result_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ITEM_W-1:0] value;
    bit                typed;
    seq_result_t       want;
  } stim_row_t;

  typedef enum int {
    PROFILE_GROW,
    PROFILE_SHRINK,
    PROFILE_MIX,
    PROFILE_WALK
  } profile_t;

  localparam seq_result_t NO_RESULT = '0;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic [ITEM_W-1:0] seq_words [CAPACITY];
  int                seq_count  = 0;
  int                seq_cursor = 0;

  seq_result_t expected_results [$];
  stim_row_t   directed_rows [$];
  int          mismatches  = 0;
  int          cycle_count = 0;
  int          items_sent  = 0;
  bit          gaps_enable  = 1'b1;
  logic        stall_enable = 1'b1;
  int          stall_left   = 0;

  cursor_sequence_buffer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic seq_result_t predict_command(logic [CMD_W-1:0] cmd,
                                                  logic [ITEM_W-1:0] value);
    seq_result_t res;
    bit          cur;
    int          i;
    cur = (seq_cursor < seq_count);
    res = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_REWIND: begin
        seq_cursor = 0;
      end
      CMD_ADVANCE: begin
        if (cur) seq_cursor++;
        else res.status = ST_NONE;
      end
      CMD_INSERT, CMD_ATTACH: begin
        if (seq_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          if (cmd == CMD_INSERT) begin
            if (!cur) seq_cursor = 0;
          end else begin
            seq_cursor = cur ? seq_cursor + 1 : seq_count;
          end
          for (i = seq_count; i > seq_cursor; i--) seq_words[i] = seq_words[i-1];
          seq_words[seq_cursor] = value;
          seq_count++;
        end
      end
      CMD_REMOVE: begin
        if (cur) begin
          for (i = seq_cursor; i + 1 < seq_count; i++) seq_words[i] = seq_words[i+1];
          seq_count--;
        end else begin
          res.status = ST_NONE;
        end
      end
      default: begin
        if (!cur) res.status = ST_NONE;
      end
    endcase
    cur = (seq_cursor < seq_count);
    res.item_value  = cur ? seq_words[seq_cursor] : '0;
    res.item_count  = POS_W'(seq_count);
    res.cursor_pos  = POS_W'(seq_cursor);
    res.has_current = cur;
    return res;
  endfunction

  function automatic void add_row(logic [CMD_W-1:0] cmd, logic [ITEM_W-1:0] value,
                                  bit typed, seq_result_t want);
    stim_row_t row;
    row.cmd   = cmd;
    row.value = value;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [ITEM_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(profile_t p);
    int r;
    r = $urandom_range(0, 99);
    case (p)
      PROFILE_GROW: begin
        if (r < 35) return CMD_INSERT;
        if (r < 70) return CMD_ATTACH;
        if (r < 80) return CMD_ADVANCE;
        if (r < 88) return CMD_REWIND;
        if (r < 94) return CMD_READ;
        if (r < 97) return CMD_REMOVE;
      end
      PROFILE_SHRINK: begin
        if (r < 50) return CMD_REMOVE;
        if (r < 65) return CMD_REWIND;
        if (r < 80) return CMD_ADVANCE;
        if (r < 90) return CMD_READ;
        if (r < 93) return CMD_INSERT;
        if (r < 96) return CMD_ATTACH;
      end
      PROFILE_WALK: begin
        if (r < 40) return CMD_ADVANCE;
        if (r < 55) return CMD_REWIND;
        if (r < 70) return CMD_READ;
        if (r < 80) return CMD_INSERT;
        if (r < 90) return CMD_ATTACH;
        if (r < 97) return CMD_REMOVE;
      end
      default: begin
        return CMD_W'($urandom_range(0, 7));
      end
    endcase
    return ($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
  endfunction

  function automatic void check_field(string name, logic [ITEM_W-1:0] want,
                                      logic [ITEM_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic set_idling(bit on);
    gaps_enable = on;
    stall_enable <= on;
  endtask

  task automatic send_command(logic [CMD_W-1:0] cmd, logic [ITEM_W-1:0] value,
                              bit typed, seq_result_t want);
    seq_result_t predicted;
    if (gaps_enable && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tdata  <= IN_DATA_W'({value, cmd});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = predict_command(cmd, value);
    expected_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic send_random(profile_t p);
    send_command(pick_command(p), rand_value(), 1'b0, NO_RESULT);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!stall_enable) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_monitor
    seq_result_t want;
    seq_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[OUT_USED_W-1:0];
      if (expected_results.size() == 0) begin
        $error("unexpected result item 0x%0h", got);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("item_value", want.item_value, got.item_value);
        check_field("status", ITEM_W'(want.status), ITEM_W'(got.status));
        check_field("item_count", ITEM_W'(want.item_count), ITEM_W'(got.item_count));
        check_field("cursor_pos", ITEM_W'(want.cursor_pos), ITEM_W'(got.cursor_pos));
        check_field("has_current", ITEM_W'(want.has_current), ITEM_W'(got.has_current));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int       seg_len;
    profile_t profile;
    for (int i = 0; i < CAPACITY; i++) seq_words[i] = '0;

    add_row(CMD_READ,     32'h0,        1, '{1'b0, 6'd0, 6'd0, ST_NONE, 32'h0});
    add_row(CMD_ADVANCE,  32'h0,        1, '{1'b0, 6'd0, 6'd0, ST_NONE, 32'h0});
    add_row(CMD_REMOVE,   32'hFFFFFFFF, 1, '{1'b0, 6'd0, 6'd0, ST_NONE, 32'h0});
    add_row(CMD_REWIND,   32'h0,        1, '{1'b0, 6'd0, 6'd0, ST_OK,   32'h0});
    add_row(CMD_SPARE_LO, 32'h0,        1, '{1'b0, 6'd0, 6'd0, ST_NONE, 32'h0});
    add_row(CMD_SPARE_HI, 32'hFFFFFFFF, 1, '{1'b0, 6'd0, 6'd0, ST_NONE, 32'h0});
    add_row(CMD_ATTACH,   32'hFFFFFFFF, 1, '{1'b1, 6'd0, 6'd1, ST_OK,   32'hFFFFFFFF});
    add_row(CMD_ADVANCE,  32'h0,        1, '{1'b0, 6'd1, 6'd1, ST_OK,   32'h0});
    add_row(CMD_ADVANCE,  32'h0,        1, '{1'b0, 6'd1, 6'd1, ST_NONE, 32'h0});
    add_row(CMD_INSERT,   32'h0,        1, '{1'b1, 6'd0, 6'd2, ST_OK,   32'h0});
    add_row(CMD_ATTACH,   32'h5A5A5A5A, 0, NO_RESULT);
    add_row(CMD_INSERT,   32'hA5A5A5A5, 0, NO_RESULT);
    add_row(CMD_READ,     32'h0,        0, NO_RESULT);
    add_row(CMD_REMOVE,   32'h0,        0, NO_RESULT);
    add_row(CMD_REWIND,   32'h0,        0, NO_RESULT);
    add_row(CMD_REMOVE,   32'h0,        0, NO_RESULT);
    add_row(CMD_SPARE_HI, 32'h0,        0, NO_RESULT);
    add_row(CMD_ADVANCE,  32'h0,        0, NO_RESULT);
    add_row(CMD_ADVANCE,  32'h0,        0, NO_RESULT);
    add_row(CMD_REMOVE,   32'h0,        0, NO_RESULT);
    add_row(CMD_ATTACH,   32'h00000001, 0, NO_RESULT);
    add_row(CMD_REWIND,   32'h0,        0, NO_RESULT);
    add_row(CMD_REMOVE,   32'h0,        0, NO_RESULT);
    add_row(CMD_READ,     32'h0,        0, NO_RESULT);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].want);
    end

    while (seq_count < CAPACITY) send_random(PROFILE_GROW);
    repeat (4) begin
      send_command(($urandom_range(0, 1) != 0) ? CMD_INSERT : CMD_ATTACH,
                   rand_value(), 1'b0, NO_RESULT);
    end
    wait_for_results();

    while (seq_count > 0) send_random(PROFILE_SHRINK);
    repeat (2) send_command(CMD_REMOVE, rand_value(), 1'b0, NO_RESULT);

    while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
      seg_len = $urandom_range(20, 60);
      profile = profile_t'($urandom_range(0, 3));
      if (items_sent < directed_rows.size() + RANDOM_ITEMS - QUIET_ITEMS) begin
        set_idling($urandom_range(0, 3) != 0);
      end
      repeat (seg_len) begin
        if (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
          if (gaps_enable &&
              items_sent >= directed_rows.size() + RANDOM_ITEMS - QUIET_ITEMS) begin
            set_idling(1'b0);
          end
          send_random(profile);
        end
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/csb_pkg.sv
design/csb_ram.sv
design/cursor_sequence_buffer.sv
verif/testbench.sv
